// ===== sv/fifo_handoff_mutex_assert.svh =====
// Assertion macros for the hardware mutex block.
`ifndef FIFO_HANDOFF_MUTEX_ASSERT_SVH
`define FIFO_HANDOFF_MUTEX_ASSERT_SVH

// Check a condition on every rising clock edge outside reset.
`define FHM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define FHM_ASSERT_IMPLY(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/fhm_pkg.sv =====
// Shared constants and types for the hardware mutex block.
`default_nettype none
package fhm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;

  // Port field widths
  localparam int TID_W    = 16;
  localparam int STATUS_W = 3;
  localparam int WCOUNT_W = 5;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request modes
  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_LOCK    = 2'd1;
  localparam logic [1:0] MODE_UNLOCK  = 2'd2;
  localparam logic [1:0] MODE_DESTROY = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACQUIRED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HANDED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd6;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd7;

  // Command from the control logic to the waiter queue
  typedef struct packed {
    logic               clear;
    logic               push;
    logic               pop;
    logic [ID_BITS-1:0] id;
  } qcmd_t;

  // One result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_BITS-1:0]  owner;
    logic                wake;
    logic [ID_BITS-1:0]  woken;
    logic [CNT_W-1:0]    count;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/fhm_queue.sv =====
// Circular FIFO of waiting thread ids with head pointer and fill count.
`default_nettype none
module fhm_queue
  import fhm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qcmd_t              cmd,
  output logic      [ID_BITS-1:0] head_id,
  output logic      [CNT_W-1:0]   count
);

  localparam int SUM_W = PTR_W + 1;

  logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   head_next;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail;

  // Locate the tail slot, wrapping past the end of the ring
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
    if (head == PTR_W'(QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + 1'b1;
    end
  end

  assign head_id = mem[head];

  // Advance head and count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      head  <= head_next;
      count <= count - 1'b1;
    end
  end

  // Store a new waiter at the tail
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      mem[tail] <= cmd.id;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fhm_core.sv =====
// Owner register and request decode for the hardware mutex.
`default_nettype none
module fhm_core
  import fhm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic [1:0]         mode,
  input  wire logic [ID_BITS-1:0] tid,
  input  wire logic [CNT_W-1:0]   q_count,
  input  wire logic [ID_BITS-1:0] q_head_id,
  output qcmd_t                   qcmd,
  output result_t                 res
);

  logic [ID_BITS-1:0] owner_id;
  logic [ID_BITS-1:0] owner_next;
  logic [CNT_W-1:0]   count_next;

  // Decode the request against the current owner and queue fill
  always_comb begin
    qcmd       = '0;
    qcmd.id    = tid;
    owner_next = owner_id;
    count_next = q_count;
    res        = '0;
    res.status = ST_IGNORED;
    case (mode)
      MODE_INIT: begin
        qcmd.clear = go;
        owner_next = '0;
        count_next = '0;
        res.status = ST_OK;
      end
      MODE_LOCK: begin
        if (tid == '0) begin
          res.status = ST_IGNORED;
        end else if (owner_id == '0) begin
          owner_next = tid;
          res.status = ST_ACQUIRED;
        end else if (q_count >= CNT_W'(QUEUE_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          qcmd.push  = go;
          count_next = q_count + 1'b1;
          res.status = ST_QUEUED;
        end
      end
      MODE_UNLOCK: begin
        if (owner_id == '0) begin
          res.status = ST_IGNORED;
        end else if (q_count != '0) begin
          qcmd.pop   = go;
          owner_next = q_head_id;
          count_next = q_count - 1'b1;
          res.wake   = 1'b1;
          res.woken  = q_head_id;
          res.status = ST_HANDED;
        end else begin
          owner_next = '0;
          res.status = ST_RELEASED;
        end
      end
      MODE_DESTROY: begin
        res.status = (q_count != '0) ? ST_FAULT : ST_OK;
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
    res.owner = owner_next;
    res.count = count_next;
  end

  // Hold the owner id between requests
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_id <= '0;
    end else if (go) begin
      owner_id <= owner_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fifo_handoff_mutex.sv =====
// Top level of the hardware mutex with a FIFO of waiting threads.
// One request (init, lock, unlock, destroy) is taken per cycle unless the result side stalls,
// and one result beat comes out for each: the request lands in an input register, the
// owner register and waiter queue are updated as it moves into the result register, and
// the result register holds its beat until taken while the next request is accepted.
// Thread id 0 means unlocked; up to QUEUE_DEPTH threads can wait, oldest first.
`default_nettype none
module fifo_handoff_mutex
  import fhm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          mode,
  input  wire logic [TID_W-1:0]    thread_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [STATUS_W-1:0] status,
  output logic      [TID_W-1:0]    owner,
  output logic                     wake_valid,
  output logic      [TID_W-1:0]    woken_thread,
  output logic      [WCOUNT_W-1:0] waiter_count
);

  `include "fifo_handoff_mutex_assert.svh"

  logic               s1_valid;
  logic [1:0]         s1_mode;
  logic [ID_BITS-1:0] s1_tid;
  logic               advance;
  logic               in_fire;
  logic [CNT_W-1:0]   q_count;
  logic [ID_BITS-1:0] q_head_id;
  qcmd_t              qcmd;
  result_t            res;
  result_t            res_q;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode <= mode;
      s1_tid  <= thread_id[ID_BITS-1:0];
    end
  end

  fhm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .cmd     (qcmd),
    .head_id (q_head_id),
    .count   (q_count)
  );

  fhm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .mode      (s1_mode),
    .tid       (s1_tid),
    .q_count   (q_count),
    .q_head_id (q_head_id),
    .qcmd      (qcmd),
    .res       (res)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign owner        = TID_W'(res_q.owner);
  assign wake_valid   = res_q.wake;
  assign woken_thread = TID_W'(res_q.woken);
  assign waiter_count = WCOUNT_W'(res_q.count);

  // Sanity checks on the result stream and the queue
  `FHM_ASSERT_ALWAYS(a_count_bound, q_count <= CNT_W'(QUEUE_DEPTH), "waiter count overflow")
  `FHM_ASSERT_IMPLY(a_wake_handed, out_valid && wake_valid, status == ST_HANDED, "wake without hand-off")
  `FHM_ASSERT_IMPLY(a_wake_owner, out_valid && wake_valid, owner == woken_thread, "woken thread is not owner")
  `FHM_ASSERT_IMPLY(a_queue_cmd, advance, !(qcmd.push && qcmd.pop), "push and pop together")

endmodule
`default_nettype wire
